/* rtl/dte_pkg.sv */
`timescale 1ns / 1ps
package dte_pkg;

   // Default number of table entries.
   localparam int DEF_TABLE_DEPTH = 16;

   // Fixed field widths of the transaction payloads.
   localparam int DL_W   = 32;
   localparam int ID_W   = 16;
   localparam int PRI_W  = 3;
   localparam int STAT_W = 3;
   localparam int HELD_W = 5;

   // Largest id before the counter wraps back to one.
   localparam logic [ID_W-1:0] ID_MAX   = 16'hFFFF;
   localparam logic [ID_W-1:0] ID_FIRST = 16'd1;

   // Operation codes of a request.
   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_EXPIRE = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   // Status codes of a response.
   typedef enum logic [STAT_W-1:0] {
      STAT_DONE      = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_DUE       = 3'd3,
      STAT_NONE_DUE  = 3'd4
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // One table entry as held in the entry memory.
   typedef struct packed {
      logic [DL_W-1:0]  deadline;
      logic [ID_W-1:0]  id;
      logic [PRI_W-1:0] prio;
   } entry_type;

endpackage

/* rtl/deadline_table_expiry.sv */
`timescale 1ns / 1ps
// Ordered deadline table. A transaction is taken when start is high and busy is low;
// every response appears for exactly one cycle with rsp_valid high and must be
// captured then, since the receiver cannot stall the block. The response to an add
// follows in the cycle after it is taken, with busy staying low. Delete and query
// walk the stored entries through the single read port of the entry memory, one
// entry per cycle. Expire walks the table once to count the due entries and, if
// any are due, a second time to emit them while packing the remaining entries
// forward, emitting each due entry as it is read. No clearing pass follows reset.
module deadline_table_expiry #(
   parameter int TABLE_DEPTH = dte_pkg::DEF_TABLE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_mode,
   input  logic [dte_pkg::DL_W-1:0]    req_new_deadline,
   input  logic [dte_pkg::PRI_W-1:0]   req_new_priority,
   input  logic [dte_pkg::ID_W-1:0]    req_target_id,
   input  logic [dte_pkg::DL_W-1:0]    req_now_time,
   output logic                        rsp_valid,
   output logic [dte_pkg::STAT_W-1:0]  rsp_status,
   output logic [dte_pkg::ID_W-1:0]    rsp_entry_id,
   output logic [dte_pkg::PRI_W-1:0]   rsp_entry_priority,
   output logic [dte_pkg::DL_W-1:0]    rsp_entry_deadline,
   output logic [dte_pkg::DL_W-1:0]    rsp_next_time,
   output logic [dte_pkg::HELD_W-1:0]  rsp_entries_held,
   output logic                        rsp_last
);
   import dte_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   // Sequencer and table bookkeeping.
   state_type        state_ff, state_in;
   mode_type         op_ff, op_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [ID_W-1:0]  id_ctr_ff, id_ctr_in;
   logic [DL_W-1:0]  now_ff, now_in;
   logic [ID_W-1:0]  tid_ff, tid_in;

   // Walk pointers and per-walk accumulators.
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             rdv_ff, rdv_in;
   logic [CNT_W-1:0] keep_ff, keep_in;
   logic [CNT_W-1:0] due_cnt_ff, due_cnt_in;
   logic [CNT_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic             found_ff, found_in;
   logic             due_any_ff, due_any_in;
   logic             best_ok_ff, best_ok_in;
   logic [DL_W-1:0]  best_ff, best_in;

   // Response registers.
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [PRI_W-1:0]  rsp_pri_ff, rsp_pri_in;
   logic [DL_W-1:0]   rsp_dl_ff, rsp_dl_in;
   logic [DL_W-1:0]   rsp_next_ff, rsp_next_in;
   logic [HELD_W-1:0] rsp_held_ff, rsp_held_in;
   logic              rsp_last_ff, rsp_last_in;

   // Memory port signals.
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic             mem_re;
   entry_type        mem_q;

   logic             accept;
   logic             walk_done;
   logic             q_due;
   logic [CNT_W-1:0] held_sel;
   logic [31:0]      held_wide;
   mode_type         req_op;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign req_op    = mode_type'(req_mode);
   assign mem_re    = busy && (rd_ptr_ff < fill_ff);
   assign walk_done = (rd_ptr_ff == fill_ff) && !rdv_ff;
   assign q_due     = (mem_q.deadline <= now_ff);
   assign held_wide = 32'(held_sel);

   dte_entry_ram #(
      .DEPTH(TABLE_DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(rd_ptr_ff[IDX_W-1:0]),
      .rd_data(mem_q)
   );

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op != MODE_ADD)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (walk_done) begin
               if ((op_ff == MODE_EXPIRE) && (due_cnt_ff != '0)) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (walk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and response logic.
   always_comb begin
      op_in       = op_ff;
      fill_in     = fill_ff;
      id_ctr_in   = id_ctr_ff;
      now_in      = now_ff;
      tid_in      = tid_ff;
      rd_ptr_in   = rd_ptr_ff;
      rdv_in      = mem_re;
      keep_in     = keep_ff;
      due_cnt_in  = due_cnt_ff;
      emit_cnt_in = emit_cnt_ff;
      found_in    = found_ff;
      due_any_in  = due_any_ff;
      best_ok_in  = best_ok_ff;
      best_in     = best_ff;

      mem_we    = 1'b0;
      mem_waddr = keep_ff[IDX_W-1:0];
      mem_wdata = mem_q;

      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_DONE;
      rsp_id_in     = '0;
      rsp_pri_in    = '0;
      rsp_dl_in     = '0;
      rsp_next_in   = '0;
      rsp_last_in   = 1'b1;
      held_sel      = fill_ff;

      if (mem_re) begin
         rd_ptr_in = rd_ptr_ff + CNT_ONE;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_op;
               now_in      = req_now_time;
               tid_in      = req_target_id;
               rd_ptr_in   = '0;
               keep_in     = '0;
               due_cnt_in  = '0;
               emit_cnt_in = '0;
               found_in    = 1'b0;
               due_any_in  = 1'b0;
               best_ok_in  = 1'b0;
               best_in     = '0;

               // Add is handled at once: append at the fill position.
               if (req_op == MODE_ADD) begin
                  rsp_valid_in = 1'b1;
                  if (fill_ff == CNT_FULL) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     mem_we         = 1'b1;
                     mem_waddr      = fill_ff[IDX_W-1:0];
                     mem_wdata.deadline = req_new_deadline;
                     mem_wdata.id   = id_ctr_ff;
                     mem_wdata.prio = req_new_priority;
                     fill_in        = fill_ff + CNT_ONE;
                     held_sel       = fill_ff + CNT_ONE;
                     rsp_id_in      = id_ctr_ff;
                     id_ctr_in      = (id_ctr_ff == ID_MAX) ? ID_FIRST : id_ctr_ff + ID_FIRST;
                  end
               end
            end
         end

         ST_SCAN: begin
            // One entry arrives from memory per cycle.
            if (rdv_ff) begin
               case (op_ff)
                  MODE_DELETE: begin
                     if (!found_ff && (mem_q.id == tid_ff)) begin
                        found_in = 1'b1;
                     end else begin
                        mem_we  = 1'b1;
                        keep_in = keep_ff + CNT_ONE;
                     end
                  end
                  MODE_EXPIRE: begin
                     if (q_due) begin
                        due_cnt_in = due_cnt_ff + CNT_ONE;
                     end
                  end
                  default: begin
                     if (q_due) begin
                        due_any_in = 1'b1;
                     end else if (!best_ok_ff || (mem_q.deadline < best_ff)) begin
                        best_in    = mem_q.deadline;
                        best_ok_in = 1'b1;
                     end
                  end
               endcase
            end

            // End of the first walk.
            if (walk_done) begin
               case (op_ff)
                  MODE_DELETE: begin
                     fill_in       = keep_ff;
                     held_sel      = keep_ff;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = found_ff ? STAT_DONE : STAT_NOT_FOUND;
                  end
                  MODE_EXPIRE: begin
                     if (due_cnt_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_NONE_DUE;
                     end else begin
                        rd_ptr_in   = '0;
                        keep_in     = '0;
                        emit_cnt_in = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_next_in  = due_any_ff ? now_ff : best_ff;
                  end
               endcase
            end
         end

         ST_EMIT: begin
            // Second expire walk: report due entries, pack the rest forward.
            held_sel = fill_ff - due_cnt_ff;
            if (rdv_ff) begin
               if (q_due) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_DUE;
                  rsp_id_in     = mem_q.id;
                  rsp_pri_in    = mem_q.prio;
                  rsp_dl_in     = mem_q.deadline;
                  rsp_last_in   = ((emit_cnt_ff + CNT_ONE) == due_cnt_ff);
                  emit_cnt_in   = emit_cnt_ff + CNT_ONE;
               end else begin
                  mem_we  = 1'b1;
                  keep_in = keep_ff + CNT_ONE;
               end
            end
            if (walk_done) begin
               fill_in = fill_ff - due_cnt_ff;
            end
         end

         default: begin
         end
      endcase

      rsp_held_in = held_wide[HELD_W-1:0];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         id_ctr_ff    <= ID_FIRST;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         id_ctr_ff    <= id_ctr_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and walk registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      now_ff        <= now_in;
      tid_ff        <= tid_in;
      rd_ptr_ff     <= rd_ptr_in;
      keep_ff       <= keep_in;
      due_cnt_ff    <= due_cnt_in;
      emit_cnt_ff   <= emit_cnt_in;
      found_ff      <= found_in;
      due_any_ff    <= due_any_in;
      best_ok_ff    <= best_ok_in;
      best_ff       <= best_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_pri_ff    <= rsp_pri_in;
      rsp_dl_ff     <= rsp_dl_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_held_ff   <= rsp_held_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_id       = rsp_id_ff;
   assign rsp_entry_priority = rsp_pri_ff;
   assign rsp_entry_deadline = rsp_dl_ff;
   assign rsp_next_time      = rsp_next_ff;
   assign rsp_entries_held   = rsp_held_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

/* rtl/dte_entry_ram.sv */
`timescale 1ns / 1ps
module dte_entry_ram #(
   parameter int DEPTH = dte_pkg::DEF_TABLE_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  dte_pkg::entry_type       wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output dte_pkg::entry_type       rd_data
);
   import dte_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
